// ===== sv/degenerate_shell_band_filler_defines.svh =====
// Assertion macros used by the checker file
`ifndef DEGENERATE_SHELL_BAND_FILLER_DEFINES_SVH
`define DEGENERATE_SHELL_BAND_FILLER_DEFINES_SVH

// clocked assertion, quiet while reset is asserted
`define DSBF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked on every edge out of reset
`define DSBF_ASSERT_IMPL(label, ante, cons, msg) \
	`DSBF_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== sv/dsbf_pkg.sv =====
// Shared constants, types and state codes of the shell band filler
package dsbf_pkg;

	localparam int NBANDS = 64;
	localparam int AW     = $clog2(NBANDS);
	localparam int CW     = AW + 1;
	localparam int E_W    = 32;
	localparam int OCC_W  = 18;
	localparam int EC_W   = 24;
	localparam int TOL_W  = 31;
	localparam int CFG_W  = 31;
	localparam int CAP_W  = OCC_W + CW;

	localparam logic [EC_W-1:0]  EC_RESET  = '0;
	localparam logic [OCC_W-1:0] MO_RESET  = 18'd131072;
	localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

	typedef enum logic [1:0] {
		CFG_ELECTRON_COUNT = 2'd0,
		CFG_MAX_OCCUPATION = 2'd1,
		CFG_DEGEN_TOL      = 2'd2,
		CFG_UNUSED         = 2'd3
	} cfg_idx_t;

	typedef enum logic [12:0] {
		S_LOAD = 13'b0000000000001,
		S_RDH  = 13'b0000000000010,
		S_HEAD = 13'b0000000000100,
		S_SCAN = 13'b0000000001000,
		S_CAP  = 13'b0000000010000,
		S_DEC  = 13'b0000000100000,
		S_DIV  = 13'b0000001000000,
		S_WR   = 13'b0000010000000,
		S_POT1 = 13'b0000100000000,
		S_POT2 = 13'b0001000000000,
		S_POT3 = 13'b0010000000000,
		S_ORD  = 13'b0100000000000,
		S_OV   = 13'b1000000000000
	} state_t;

	typedef struct packed {
		logic            start;
		logic [EC_W-1:0] dividend;
		logic [CW-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [EC_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== sv/dsbf_ifs.sv =====
// Band input and result output channel interfaces
interface dsbf_band_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] band_energy;
	logic              last_band;
	modport source (output valid, band_energy, last_band, input ready);
	modport sink (input valid, band_energy, last_band, output ready);
endinterface

interface dsbf_result_if;
	logic               valid;
	logic               ready;
	logic [17:0]        occupation;
	logic [5:0]         band_number;
	logic               final_result;
	logic signed [31:0] chemical_potential;
	logic [23:0]        occupation_sum;
	logic               capacity_error;
	modport source (output valid, occupation, band_number, final_result, chemical_potential,
		occupation_sum, capacity_error, input ready);
	modport sink (input valid, occupation, band_number, final_result, chemical_potential,
		occupation_sum, capacity_error, output ready);
endinterface

// ===== sv/degenerate_shell_band_filler.sv =====
// Top level: loads bands, walks shells, fills occupations, emits results
//
//   channel | dir | payload
//   band    | in  | band_energy, last_band
//   result  | out | occupation, band_number, final_result, chemical_potential,
//           |     | occupation_sum, capacity_error
//   cfg     | in  | cfg_write_en, cfg_index, cfg_data
//
// A non-last band is written to the energy RAM. On the last band a sequencer walks the
// shells: for each shell it reads the head energy, scans the energy RAM for close bands,
// computes the capacity and writes the occupations (restoring divider for a partly filled shell).
// Then the potential is computed, and each result takes an occupation RAM read,
// then an output hold until the transfer.
// Reset clears control state only; RAM contents are undefined.
module degenerate_shell_band_filler import dsbf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	dsbf_band_if.sink          band,
	dsbf_result_if.source      result
);
	state_t state_q;

	logic [EC_W-1:0]  ec_q;
	logic [OCC_W-1:0] mo_q;
	logic [TOL_W-1:0] tol_q;

	logic [CW-1:0]    cnt_q, n_q, i_q, j_q, fill_end_q;
	logic             ovf_q, err_q;
	logic [E_W-1:0]   efirst_q, mu_q;
	logic [EC_W-1:0]  rem_q, sum_q;
	logic [CAP_W-1:0] cap_q;
	logic [OCC_W-1:0] fval_q;
	logic [AW-1:0]    lo_q, pf_idx_q, b_q;
	logic             lo_vld_q, nf_seen_q, pf_ok_q, mid_q;

	logic             accept;
	logic [CW-1:0]    n_new;
	logic             ovf_new, err_new;
	logic [E_W-1:0]   e_rd;
	logic [AW-1:0]    e_raddr;
	logic [OCC_W-1:0] occ_rd;
	logic [E_W:0]     diff, absd;
	logic             close;
	logic [CW-1:0]    size;
	logic [CW-1:0]    lo_next;
	logic             is_final;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q  <= EC_RESET;
			mo_q  <= MO_RESET;
			tol_q <= TOL_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ELECTRON_COUNT: ec_q  <= cfg_data[EC_W-1:0];
				CFG_MAX_OCCUPATION: mo_q  <= cfg_data[OCC_W-1:0];
				CFG_DEGEN_TOL:      tol_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign band.ready = (state_q == S_LOAD);
	assign accept     = band.valid && band.ready;
	assign n_new      = cnt_q + CW'(!cnt_q[CW-1]);
	assign ovf_new    = ovf_q || cnt_q[CW-1];
	assign err_new    = ovf_new || ({{CAP_W-EC_W{1'b0}}, ec_q} > mo_q * n_new);

	assign diff    = $signed({e_rd[E_W-1], e_rd}) - $signed({efirst_q[E_W-1], efirst_q});
	assign absd    = diff[E_W] ? (~diff + 1'b1) : diff;
	assign close   = absd < {2'b00, tol_q};
	assign size    = j_q - i_q;
	assign lo_next = {1'b0, lo_q} + 1'b1;
	assign is_final = ({1'b0, b_q} + 1'b1) == n_q;

	always_comb begin
		unique case (state_q)
			S_RDH:   e_raddr = i_q[AW-1:0];
			S_HEAD:  e_raddr = AW'(i_q + 1'b1);
			S_SCAN:  e_raddr = AW'(j_q + 1'b1);
			S_POT1:  e_raddr = pf_ok_q ? pf_idx_q : (lo_vld_q ? lo_q : '0);
			S_POT2:  e_raddr = lo_next[AW-1:0];
			default: e_raddr = '0;
		endcase
	end

	dsbf_ram #(.WIDTH(E_W), .DEPTH(NBANDS)) u_energy (
		.clk   (clk),
		.we    (accept && !cnt_q[CW-1]),
		.waddr (cnt_q[AW-1:0]),
		.wdata (band.band_energy),
		.re    (1'b1),
		.raddr (e_raddr),
		.rdata (e_rd)
	);

	dsbf_ram #(.WIDTH(OCC_W), .DEPTH(NBANDS)) u_occ (
		.clk   (clk),
		.we    (state_q == S_WR),
		.waddr (i_q[AW-1:0]),
		.wdata (fval_q),
		.re    (state_q == S_ORD),
		.raddr (b_q),
		.rdata (occ_rd)
	);

	assign div_req.start    = (state_q == S_DEC) && ({1'b0, rem_q} < cap_q);
	assign div_req.dividend = rem_q;
	assign div_req.divisor  = size;

	dsbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (band.last_band) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							if (err_new) begin
								state_q <= S_ORD;
							end else if (ec_q == '0) begin
								state_q <= S_POT1;
							end else begin
								state_q <= S_RDH;
							end
						end else begin
							cnt_q <= n_new;
							ovf_q <= ovf_new;
						end
					end
				end
				S_RDH: state_q <= S_HEAD;
				S_HEAD: state_q <= ((i_q + 1'b1) < n_q) ? S_SCAN : S_CAP;
				S_SCAN: begin
					if (!close || (j_q + 1'b1) >= n_q) begin
						state_q <= S_CAP;
					end
				end
				S_CAP: state_q <= S_DEC;
				S_DEC: state_q <= div_req.start ? S_DIV : S_WR;
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					if ((i_q + 1'b1) == j_q) begin
						state_q <= (j_q < n_q && rem_q != '0) ? S_RDH : S_POT1;
					end
				end
				S_POT1: state_q <= S_POT2;
				S_POT2: state_q <= mid_q ? S_POT3 : S_ORD;
				S_POT3: state_q <= S_ORD;
				S_ORD: state_q <= S_OV;
				S_OV: begin
					if (result.ready) begin
						state_q <= is_final ? S_LOAD : S_ORD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LOAD: begin
				if (accept && band.last_band) begin
					n_q        <= n_new;
					err_q      <= err_new;
					rem_q      <= ec_q;
					i_q        <= '0;
					sum_q      <= '0;
					lo_vld_q   <= 1'b0;
					nf_seen_q  <= 1'b0;
					pf_ok_q    <= 1'b0;
					fill_end_q <= '0;
					mu_q       <= '0;
					b_q        <= '0;
				end
			end
			S_HEAD: begin
				efirst_q <= e_rd;
				j_q      <= i_q + 1'b1;
			end
			S_SCAN: begin
				if (close) begin
					j_q <= j_q + 1'b1;
				end
			end
			S_CAP: cap_q <= mo_q * size;
			S_DEC: begin
				if (!div_req.start) begin
					fval_q <= mo_q;
					rem_q  <= rem_q - cap_q[EC_W-1:0];
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					fval_q <= div_rsp.quotient[OCC_W-1:0];
					rem_q  <= '0;
				end
			end
			S_WR: begin
				sum_q <= sum_q + EC_W'(fval_q);
				i_q   <= i_q + 1'b1;
				if (fval_q != '0) begin
					lo_q     <= i_q[AW-1:0];
					lo_vld_q <= 1'b1;
				end
				if (!nf_seen_q && fval_q < mo_q) begin
					nf_seen_q <= 1'b1;
					pf_ok_q   <= (fval_q != '0);
					pf_idx_q  <= i_q[AW-1:0];
				end
				if ((i_q + 1'b1) == j_q) begin
					fill_end_q <= j_q;
				end
			end
			S_POT1: mid_q <= !pf_ok_q && lo_vld_q && (lo_next < n_q);
			S_POT2: mu_q <= e_rd;
			S_POT3: begin
				mu_q <= E_W'(($signed({mu_q[E_W-1], mu_q}) + $signed({e_rd[E_W-1], e_rd})) >>> 1);
			end
			S_OV: begin
				if (result.ready && !is_final) begin
					b_q <= b_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// error answers: fill_end, sum and potential stay zero
	assign result.valid              = (state_q == S_OV);
	assign result.occupation         = ({1'b0, b_q} < fill_end_q) ? occ_rd : '0;
	assign result.band_number        = b_q;
	assign result.final_result       = is_final;
	assign result.chemical_potential = mu_q;
	assign result.occupation_sum     = sum_q;
	assign result.capacity_error     = err_q;
endmodule

// ===== sv/dsbf_ram.sv =====
// Generic single write, single read RAM with registered read data
module dsbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== sv/dsbf_div.sv =====
// Restoring divider, one quotient bit per cycle
module dsbf_div import dsbf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic            busy_q;
	logic            done_q;
	logic [4:0]      cnt_q;
	logic [EC_W-1:0] q_q;
	logic [CW-1:0]   r_q;
	logic [CW-1:0]   d_q;
	logic [CW+1:0]   trial;

	assign trial = {1'b0, r_q, q_q[EC_W-1]} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(EC_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.dividend;
			r_q <= '0;
			d_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[CW+1]) begin
				r_q <= trial[CW-1:0];
				q_q <= {q_q[EC_W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[CW-2:0], q_q[EC_W-1]};
				q_q <= {q_q[EC_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = q_q;
endmodule

// ===== sv/dsbf_checker.sv =====
// Port-level checker for the shell band filler, bound to the top level
`include "degenerate_shell_band_filler_defines.svh"

module dsbf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_final,
	input logic [17:0] out_occupation,
	input logic [23:0] out_sum,
	input logic        out_error
);
	`DSBF_ASSERT_IMPL(a_out_hold, out_valid && !out_ready, ##1 out_valid, "result dropped while stalled")
	`DSBF_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken during emit")
	`DSBF_ASSERT_IMPL(a_back_to_load, out_valid && out_ready && out_final, ##1 in_ready, "not ready after final transfer")
	`DSBF_ASSERT_IMPL(a_err_zero, out_valid && out_error, out_occupation == '0 && out_sum == '0, "nonzero result on capacity error")
endmodule

bind degenerate_shell_band_filler dsbf_checker u_dsbf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (band.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_final      (result.final_result),
	.out_occupation (result.occupation),
	.out_sum        (result.occupation_sum),
	.out_error      (result.capacity_error)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the degenerate shell band filler
module testbench;
	import dsbf_pkg::*;

	typedef struct {
		logic [17:0]        occ;
		logic [5:0]         band;
		logic               fin;
		logic signed [31:0] mu;
		logic [23:0]        sum;
		logic               err;
	} occ_result_t;

	typedef struct {
		bit                 is_cfg;
		cfg_idx_t           idx;
		logic [30:0]        val;
		logic signed [31:0] energy;
		bit                 last;
		bit                 typed;
		logic [17:0]        occ;
		logic signed [31:0] mu;
		logic [23:0]        sum;
		bit                 err;
	} stim_row_t;

	localparam int N_ROWS = 25;

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	dsbf_band_if band ();
	dsbf_result_if result ();

	degenerate_shell_band_filler u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.band         (band),
		.result       (result)
	);

	// shadow of the block
	logic [23:0]        sh_electrons;
	logic [17:0]        sh_max_occ;
	logic [30:0]        sh_tol;
	logic signed [31:0] sh_energy [NBANDS];
	logic [17:0]        sh_occ [NBANDS];
	int                 sh_loaded;
	bit                 sh_overflow;

	occ_result_t expected_occ [$];
	int  mismatches;
	bit  quiet;
	stim_row_t rows [N_ROWS];

	always #1 clk = ~clk;

	function automatic void fill_and_queue();
		int n;
		int i;
		int j;
		int hi_occ;
		int first_nf;
		bit err;
		logic [31:0] remaining;
		logic [31:0] cap;
		logic [23:0] sum;
		longint mu;
		occ_result_t r;
		n = sh_loaded;
		sum = 0;
		mu = 0;
		err = sh_overflow || (longint'(sh_electrons) > longint'(sh_max_occ) * n);
		for (i = 0; i < n; i++) sh_occ[i] = 0;
		if (!err) begin
			remaining = 32'(sh_electrons);
			i = 0;
			while (i < n && remaining > 0) begin
				j = i + 1;
				while (j < n && ((longint'(sh_energy[j]) - longint'(sh_energy[i]) < 0) ?
						-(longint'(sh_energy[j]) - longint'(sh_energy[i])) :
						(longint'(sh_energy[j]) - longint'(sh_energy[i])))
						< longint'(sh_tol))
					j++;
				cap = sh_max_occ * (j - i);
				if (remaining >= cap) begin
					for (int k = i; k < j; k++) sh_occ[k] = sh_max_occ;
					remaining -= cap;
				end else begin
					for (int k = i; k < j; k++) sh_occ[k] = 18'(remaining / (j - i));
					remaining = 0;
				end
				i = j;
			end
			hi_occ = -1;
			first_nf = -1;
			for (i = 0; i < n; i++) begin
				sum += 24'(sh_occ[i]);
				if (sh_occ[i] > 0) hi_occ = i;
				if (first_nf < 0 && sh_occ[i] < sh_max_occ) first_nf = i;
			end
			if (first_nf >= 0 && sh_occ[first_nf] > 0 && sh_occ[first_nf] < sh_max_occ)
				mu = longint'(sh_energy[first_nf]);
			else if (hi_occ >= 0 && hi_occ + 1 < n)
				mu = (longint'(sh_energy[hi_occ]) + longint'(sh_energy[hi_occ + 1])) >>> 1;
			else if (hi_occ >= 0)
				mu = longint'(sh_energy[hi_occ]);
			else
				mu = longint'(sh_energy[0]);
		end
		for (i = 0; i < n; i++) begin
			r.occ  = sh_occ[i];
			r.band = 6'(i);
			r.fin  = (i + 1 == n);
			r.mu   = mu[31:0];
			r.sum  = sum;
			r.err  = err;
			expected_occ = {expected_occ, r};
		end
		sh_loaded = 0;
		sh_overflow = 0;
	endfunction

	function automatic void accept_band(logic signed [31:0] e, bit last);
		if (sh_loaded < NBANDS) begin
			sh_energy[sh_loaded] = e;
			sh_loaded++;
		end else begin
			sh_overflow = 1;
		end
		if (last) fill_and_queue();
	endfunction

	task automatic send_band(logic signed [31:0] e, bit last);
		while (!quiet && $urandom_range(0, 99) < 20) begin
			band.valid <= 1'b0;
			@(posedge clk);
		end
		band.valid       <= 1'b1;
		band.band_energy <= e;
		band.last_band   <= last;
		do @(posedge clk); while (!band.ready);
		accept_band(e, last);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [30:0] val);
		band.valid <= 1'b0;
		while (expected_occ.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			CFG_ELECTRON_COUNT: sh_electrons = val[23:0];
			CFG_MAX_OCCUPATION: sh_max_occ = val[17:0];
			CFG_DEGEN_TOL:      sh_tol = val;
			default: ;
		endcase
	endtask

	// result side: random backpressure and checking
	always @(posedge clk) begin
		occ_result_t x;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (expected_occ.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result band %0d", result.band_number);
				end else begin
					x = expected_occ.pop_front();
					if (result.occupation !== x.occ || result.band_number !== x.band ||
							result.final_result !== x.fin || result.chemical_potential !== x.mu ||
							result.occupation_sum !== x.sum || result.capacity_error !== x.err) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp occ %h band %0d fin %b mu %h sum %h err %b, got occ %h band %0d fin %b mu %h sum %h err %b",
								x.occ, x.band, x.fin, x.mu, x.sum, x.err,
								result.occupation, result.band_number, result.final_result,
								result.chemical_potential, result.occupation_sum,
								result.capacity_error);
					end
				end
			end
			result.ready <= quiet || ($urandom_range(0, 99) >= 20);
		end
	end

	initial begin
		#4000000;
		$display("degenerate_shell_band_filler regression: fail");
		$finish;
	end

	initial begin
		int sent;
		int n;
		int mo;
		logic signed [31:0] e;
		occ_result_t t;
		clk = 0;
		arst_n = 0;
		cfg_write_en = 0;
		cfg_index = CFG_ELECTRON_COUNT;
		cfg_data = '0;
		band.valid = 0;
		band.band_energy = 0;
		band.last_band = 0;
		result.ready = 0;
		mismatches = 0;
		quiet = 0;
		sh_electrons = EC_RESET;
		sh_max_occ = MO_RESET;
		sh_tol = TOL_RESET;
		sh_loaded = 0;
		sh_overflow = 0;

		rows[0]  = '{0, CFG_UNUSED, 0, 32'sh7FFFFFFF, 1, 1, 0, 32'sh7FFFFFFF, 0, 0};
		rows[1]  = '{0, CFG_UNUSED, 0, 32'sh80000000, 1, 1, 0, 32'sh80000000, 0, 0};
		rows[2]  = '{1, CFG_ELECTRON_COUNT, 131072, 0, 0, 0, 0, 0, 0, 0};
		rows[3]  = '{0, CFG_UNUSED, 0, 5, 1, 1, 131072, 5, 131072, 0};
		rows[4]  = '{1, CFG_ELECTRON_COUNT, 8388608, 0, 0, 0, 0, 0, 0, 0};
		// charge above capacity
		rows[5]  = '{0, CFG_UNUSED, 0, -3, 1, 1, 0, 0, 0, 1};
		rows[6]  = '{1, CFG_ELECTRON_COUNT, 196608, 0, 0, 0, 0, 0, 0, 0};
		rows[7]  = '{0, CFG_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0};
		rows[8]  = '{0, CFG_UNUSED, 0, 65, 0, 0, 0, 0, 0, 0};
		rows[9]  = '{0, CFG_UNUSED, 0, 66, 0, 0, 0, 0, 0, 0};
		rows[10] = '{0, CFG_UNUSED, 0, 200, 1, 0, 0, 0, 0, 0};
		// zero tolerance: one shell per band
		rows[11] = '{1, CFG_DEGEN_TOL, 0, 0, 0, 0, 0, 0, 0, 0};
		rows[12] = '{0, CFG_UNUSED, 0, 100, 0, 0, 0, 0, 0, 0};
		rows[13] = '{0, CFG_UNUSED, 0, 100, 0, 0, 0, 0, 0, 0};
		rows[14] = '{0, CFG_UNUSED, 0, -100, 1, 0, 0, 0, 0, 0};
		rows[15] = '{1, CFG_MAX_OCCUPATION, 0, 0, 0, 0, 0, 0, 0, 0};
		rows[16] = '{1, CFG_ELECTRON_COUNT, 0, 0, 0, 0, 0, 0, 0, 0};
		rows[17] = '{0, CFG_UNUSED, 0, 9, 1, 1, 0, 9, 0, 0};
		rows[18] = '{1, CFG_MAX_OCCUPATION, 131072, 0, 0, 0, 0, 0, 0, 0};
		rows[19] = '{1, CFG_DEGEN_TOL, 31'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0};
		rows[20] = '{1, CFG_ELECTRON_COUNT, 5, 0, 0, 0, 0, 0, 0, 0};
		rows[21] = '{0, CFG_UNUSED, 0, 32'sh80000000, 0, 0, 0, 0, 0, 0};
		rows[22] = '{0, CFG_UNUSED, 0, 32'sh7FFFFFFF, 1, 0, 0, 0, 0, 0};
		// write to an index past the register list is ignored
		rows[23] = '{1, CFG_UNUSED, 123, 0, 0, 0, 0, 0, 0, 0};
		rows[24] = '{1, CFG_DEGEN_TOL, 66, 0, 0, 0, 0, 0, 0, 0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				write_reg(rows[i].idx, rows[i].val);
			end else begin
				send_band(rows[i].energy, rows[i].last);
				if (rows[i].typed) begin
					t = '{rows[i].occ, 0, 1, rows[i].mu, rows[i].sum, rows[i].err};
					expected_occ[expected_occ.size() - 1] = t;
				end
			end
		end
		// too many bands in one set
		for (int i = 0; i < 66; i++) send_band($urandom, i == 65);

		sent = 0;
		while (sent < 90) begin
			case ($urandom_range(0, 3))
				0: mo = 0;
				1: mo = 131072;
				default: mo = $urandom_range(1, 131072);
			endcase
			write_reg(CFG_MAX_OCCUPATION, 31'(mo));
			case ($urandom_range(0, 3))
				0: write_reg(CFG_DEGEN_TOL, 0);
				1: write_reg(CFG_DEGEN_TOL, 31'($urandom_range(0, 31'h7FFFFFFF)));
				default: write_reg(CFG_DEGEN_TOL, 31'($urandom_range(0, 400)));
			endcase
			if ($urandom_range(0, 9) == 0)
				write_reg(CFG_ELECTRON_COUNT, 31'(8388608));
			else
				write_reg(CFG_ELECTRON_COUNT,
					31'($urandom_range(0, (mo * 6 > 8388608) ? 8388608 : mo * 6)));
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 19))
					0: n = 64;
					1: n = $urandom_range(65, 67);
					default: n = $urandom_range(1, 8);
				endcase
				quiet = (sent >= 20 && sent < 60);
				e = $urandom;
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 7) == 0)
						e = $urandom;
					else
						e = e + $signed($urandom_range(0, 300)) - 50;
					send_band(e, i == n - 1);
					sent++;
				end
			end
		end
		quiet = 0;
		band.valid <= 1'b0;
		while (expected_occ.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_occ.size() == 0)
			$display("degenerate_shell_band_filler regression: pass");
		else
			$display("degenerate_shell_band_filler regression: fail");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/dsbf_pkg.sv
sv/dsbf_ifs.sv
sv/dsbf_ram.sv
sv/dsbf_div.sv
sv/degenerate_shell_band_filler.sv
sv/dsbf_checker.sv
tb/testbench.sv
